FILE: hdl/sts_pkg.sv
// Shared types and constants for the sphere triangle subdivider.
// No dependencies; every other file imports this package.
`default_nettype none
package sts_pkg;
	localparam int COORD_W = 16;
	localparam int ROOT_W  = 16;
	localparam int LEN_W   = 34;
	localparam int TL_W    = 50;
	localparam int STEPS   = 16;
	localparam int SUB_W   = 2;
	localparam logic [SUB_W-1:0] SUB_CORNER0 = 2'd0;
	localparam logic [SUB_W-1:0] SUB_CORNER1 = 2'd1;
	localparam logic [SUB_W-1:0] SUB_CORNER2 = 2'd2;
	localparam logic [SUB_W-1:0] SUB_CENTRE  = 2'd3;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sd32767;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p0_z;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p1_z;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p2_z;
	} face_t;

	typedef struct packed {
		coord_t q0_x;
		coord_t q0_y;
		coord_t q0_z;
		coord_t q1_x;
		coord_t q1_y;
		coord_t q1_z;
		coord_t q2_x;
		coord_t q2_y;
		coord_t q2_z;
		logic [SUB_W-1:0] sub_index;
		logic last_child;
	} child_t;
endpackage
`default_nettype wire

FILE: hdl/sts_mid.sv
// Projected edge midpoint: sum, squares, then a 16-stage restoring root search.
// Depends on sts_pkg.
`default_nettype none
module sts_mid import sts_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire vec_t a,
	input  wire vec_t b,
	output vec_t      mid
);
	localparam int RW = 35 + 2 * FRAC_BITS;
	localparam int CW = ((RW > 68) ? RW : 68) + 1;
	localparam int SQ_W = 2 * COORD_W + 2;

	coord_t a_ax [3];
	coord_t b_ax [3];
	assign a_ax[0] = a.x;
	assign a_ax[1] = a.y;
	assign a_ax[2] = a.z;
	assign b_ax[0] = b.x;
	assign b_ax[1] = b.y;
	assign b_ax[2] = b.z;

	logic signed [COORD_W:0] sum_s1 [3];
	logic signed [SQ_W-1:0] prod [3];
	logic [SQ_W-1:0] sq_s2 [3];
	logic neg_s2 [3];

	logic [LEN_W-1:0] len_s [STEPS+1];
	logic zero_s [STEPS+1];
	logic [CW-1:0] rem_s [3][STEPS+1];
	logic [TL_W-1:0] tl_s [3][STEPS+1];
	logic [ROOT_W-1:0] u_s [3][STEPS+1];
	logic neg_s [3][STEPS+1];

	coord_t m_ax [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sum_s1[i] <= (COORD_W+1)'(a_ax[i]) + (COORD_W+1)'(b_ax[i]);
				sq_s2[i]  <= $unsigned(prod[i]);
				neg_s2[i] <= sum_s1[i][COORD_W];
			end
			len_s[0]  <= LEN_W'(sq_s2[0]) + LEN_W'(sq_s2[1]) + LEN_W'(sq_s2[2]);
			zero_s[0] <= (sq_s2[0] | sq_s2[1] | sq_s2[2]) == '0;
		end
	end

	// Seed the root search for each axis.
	for (genvar i = 0; i < 3; i++) begin : g_init
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i][0] <= CW'(sq_s2[i]) << (2 * FRAC_BITS + 2);
				tl_s[i][0]  <= '0;
				u_s[i][0]   <= '0;
				neg_s[i][0] <= neg_s2[i];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_sq
		assign prod[i] = sum_s1[i] * sum_s1[i];
	end

	// One root bit per stage: try u + 2^B, keeping rem = R - u^2 L and tl = u L.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int B = STEPS - 1 - k;
		always_ff @(posedge clk) begin
			if (en) begin
				len_s[k+1]  <= len_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
		for (genvar i = 0; i < 3; i++) begin : g_ax
			logic [CW-1:0] trial;
			logic fits;
			assign trial = (CW'(tl_s[i][k]) << (B + 1)) + (CW'(len_s[k]) << (2 * B));
			assign fits  = trial <= rem_s[i][k];
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i][k+1] <= fits ? rem_s[i][k] - trial : rem_s[i][k];
					tl_s[i][k+1]  <= fits ? tl_s[i][k] + (TL_W'(len_s[k]) << B) : tl_s[i][k];
					u_s[i][k+1]   <= fits ? (u_s[i][k] | (ROOT_W'(1) << B)) : u_s[i][k];
					neg_s[i][k+1] <= neg_s[i][k];
				end
			end
		end
	end

	// Round to nearest: q = (u + 1) / 2, then sign and clamp.
	for (genvar i = 0; i < 3; i++) begin : g_out
		logic [ROOT_W:0] q;
		assign q = (ROOT_W'(u_s[i][STEPS]) + (ROOT_W+1)'(1)) >> 1;
		always_comb begin
			if (zero_s[STEPS]) begin
				m_ax[i] = '0;
			end else if (neg_s[i][STEPS]) begin
				m_ax[i] = -$signed(COORD_W'(q));
			end else if (q > (ROOT_W+1)'(COORD_MAX)) begin
				m_ax[i] = COORD_MAX;
			end else begin
				m_ax[i] = $signed(COORD_W'(q));
			end
		end
	end

	assign mid.x = m_ax[0];
	assign mid.y = m_ax[1];
	assign mid.z = m_ax[2];
endmodule
`default_nettype wire

FILE: hdl/sts_ser.sv
// Output stage: holds one subdivided face and issues its four children.
// Depends on sts_pkg.
`default_nettype none
module sts_ser import sts_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load_vld,
	input  wire vec_t   p0,
	input  wire vec_t   p1,
	input  wire vec_t   p2,
	input  wire vec_t   m01,
	input  wire vec_t   m12,
	input  wire vec_t   m20,
	output logic        take,
	output logic        busy,
	output logic        child_valid,
	input  wire logic   child_ready,
	output child_t      child
);
	logic busy_q;
	logic [SUB_W-1:0] idx_q;
	vec_t p0_q, p1_q, p2_q, m01_q, m12_q, m20_q;
	vec_t a, b, c;
	logic done;

	assign done = child_ready && idx_q == SUB_CENTRE;
	assign take = load_vld && (!busy_q || done);
	assign busy = busy_q;
	assign child_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= SUB_CORNER0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= SUB_CORNER0;
		end else if (busy_q && child_ready) begin
			busy_q <= idx_q != SUB_CENTRE;
			idx_q  <= idx_q + SUB_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p0_q  <= p0;
			p1_q  <= p1;
			p2_q  <= p2;
			m01_q <= m01;
			m12_q <= m12;
			m20_q <= m20;
		end
	end

	always_comb begin
		case (idx_q)
			SUB_CORNER0: begin a = p0_q;  b = m01_q; c = m20_q; end
			SUB_CORNER1: begin a = p1_q;  b = m12_q; c = m01_q; end
			SUB_CORNER2: begin a = p2_q;  b = m20_q; c = m12_q; end
			default:     begin a = m01_q; b = m12_q; c = m20_q; end
		endcase
	end

	assign child.q0_x = a.x;
	assign child.q0_y = a.y;
	assign child.q0_z = a.z;
	assign child.q1_x = b.x;
	assign child.q1_y = b.y;
	assign child.q1_z = b.z;
	assign child.q2_x = c.x;
	assign child.q2_y = c.y;
	assign child.q2_z = c.z;
	assign child.sub_index = idx_q;
	assign child.last_child = idx_q == SUB_CENTRE;
endmodule
`default_nettype wire

FILE: hdl/sphere_triangle_subdivider.sv
// Sphere triangle subdivider top level: three midpoint units plus output stage.
// Depends on sts_pkg, sts_mid, sts_ser.
//
// Usage:
//   face channel (face_valid/face_ready/face) takes one triangle per beat,
//   three vertices in signed fixed point with COORD_FRAC_BITS fraction bits.
//   child channel (child_valid/child_ready/child) returns four beats per
//   face: corner 0, corner 1, corner 2, then the centre triangle, which
//   carries last_child. Midpoints are renormalized onto the unit sphere with
//   round-to-nearest; a zero-length midpoint becomes the zero vector.
// Pipeline: 19 stages (sum, square, length, then one root bit per stage
//   over 16 stages), followed by the output register in sts_ser.
// Throughput: each face needs four child beats on the single output
//   channel; the pipeline itself can take a face every cycle while not stalled.
// Reset clears the valid bits and the output stage; data registers are not
//   reset. When the receiver stalls, the output register holds its child and
//   the whole pipeline freezes once its last stage is full; nothing is lost.
`default_nettype none
module sphere_triangle_subdivider import sts_pkg::*; #(
	parameter int COORD_FRAC_BITS = 14
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   face_valid,
	output logic        face_ready,
	input  wire face_t  face,
	output logic        child_valid,
	input  wire logic   child_ready,
	output child_t      child
);
	localparam int DEPTH = 3 + STEPS;

	logic en;
	logic take;
	logic busy;
	logic vld_s [DEPTH];
	vec_t v0_s [DEPTH];
	vec_t v1_s [DEPTH];
	vec_t v2_s [DEPTH];
	vec_t v0, v1, v2;
	vec_t m01, m12, m20;

	assign v0 = '{x: face.p0_x, y: face.p0_y, z: face.p0_z};
	assign v1 = '{x: face.p1_x, y: face.p1_y, z: face.p1_z};
	assign v2 = '{x: face.p2_x, y: face.p2_y, z: face.p2_z};

	// Advance the whole pipe when its last stage is empty or drains this cycle.
	assign en = !vld_s[DEPTH-1] || take;
	assign face_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= face_valid;
			for (int k = 1; k < DEPTH; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Corner vertices ride along unchanged.
	always_ff @(posedge clk) begin
		if (en) begin
			v0_s[0] <= v0;
			v1_s[0] <= v1;
			v2_s[0] <= v2;
			for (int k = 1; k < DEPTH; k++) begin
				v0_s[k] <= v0_s[k-1];
				v1_s[k] <= v1_s[k-1];
				v2_s[k] <= v2_s[k-1];
			end
		end
	end

	sts_mid #(.FRAC_BITS(COORD_FRAC_BITS)) u_mid01 (
		.clk(clk), .en(en), .a(v0), .b(v1), .mid(m01)
	);
	sts_mid #(.FRAC_BITS(COORD_FRAC_BITS)) u_mid12 (
		.clk(clk), .en(en), .a(v1), .b(v2), .mid(m12)
	);
	sts_mid #(.FRAC_BITS(COORD_FRAC_BITS)) u_mid20 (
		.clk(clk), .en(en), .a(v2), .b(v0), .mid(m20)
	);

	sts_ser u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.load_vld(vld_s[DEPTH-1]),
		.p0(v0_s[DEPTH-1]),
		.p1(v1_s[DEPTH-1]),
		.p2(v2_s[DEPTH-1]),
		.m01(m01),
		.m12(m12),
		.m20(m20),
		.take(take),
		.busy(busy),
		.child_valid(child_valid),
		.child_ready(child_ready),
		.child(child)
	);

	// Hold a stalled child beat.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		child_valid && !child_ready |=> child_valid && $stable(child))
		else $error("child beat dropped while stalled");

	// The last-child flag marks exactly the centre triangle.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		child_valid |-> (child.last_child == (child.sub_index == SUB_CENTRE)))
		else $error("last_child out of step with sub_index");

	// Back-pressure on the face channel only with a full last stage and busy output.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!face_ready |-> vld_s[DEPTH-1] && busy)
		else $error("face channel stalled without cause");
endmodule
`default_nettype wire
